/* sv/sha256_stream_hasher_defines.svh */
// ---------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/shs_pkg.sv */
// ---------------------------------------------------------------------------
// sha256 stream hasher package
// round constants, initial hash values and front-to-back command type
// ---------------------------------------------------------------------------
`default_nettype none
package shs_pkg;

    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // command queued from the front to the back
    typedef struct packed {
        logic        finish;
        logic [7:0]  data;
    } cmd_t;

    typedef logic [31:0] word_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// absorb: the back end takes a byte whenever it is idle; every 64th byte starts a
// block (16 schedule loads, 64 rounds of the single round unit, one feed-forward)
// finish: 64 minus fill pad bytes and one block; when 56 or more bytes wait, a full
// block of padding and a second block; then eight words, one per cycle while tready is high
// a four-entry queue lets the input run ahead while a block compresses
// reset: asynchronous active low, restores initial hash values and empties the queue
// ---------------------------------------------------------------------------
// sha256 stream hasher
// byte-stream SHA-256 with digest emitted as eight 32-bit words
// ---------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // message_byte
    input  wire logic          s_axis_tuser,   // func
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [39:0]        m_axis_tdata,   // digest_word[31:0], word_index[34:32]
    output logic               m_axis_tlast    // last_word
);
    logic          cmd_valid, cmd_ready;
    shs_pkg::cmd_t cmd;

    // classify and queue input words
    shs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    // hashing engine
    shs_core u_core (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tlast(m_axis_tlast)
    );
endmodule
`default_nettype wire

/* sv/shs_front.sv */
// ---------------------------------------------------------------------------
// sha256 front end
// takes input words, classifies them and pushes commands into a small queue
// ---------------------------------------------------------------------------
`default_nettype none
module shs_front #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tuser,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output shs_pkg::cmd_t      cmd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    shs_pkg::cmd_t      mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               push, pop;

    assign s_tready  = (count_reg != (AW+1)'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg].finish <= (s_tuser == shs_pkg::FUNC_FINISH);
            mem[wr_ptr_reg].data   <= s_tdata;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* sv/shs_core.sv */
// ---------------------------------------------------------------------------
// sha256 back end
// block buffer, padding, round engine and digest output register
// ---------------------------------------------------------------------------
`default_nettype none
module shs_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire shs_pkg::cmd_t cmd,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata,
    output logic               m_tlast
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
    } state_t;

    state_t         state_reg;
    logic [31:0]    buf_mem [16];   // block buffer, big-endian bytes within each word
    logic [5:0]     fill_reg;
    logic [63:0]    bits_reg;
    logic [63:0]    total_reg;
    logic           finishing_reg;  // compression is part of a finish
    logic           second_reg;     // the current block is the length-only second block
    logic [5:0]     idx_reg;        // pad pointer, load index and round counter
    logic [31:0]    h_reg [8];
    logic [31:0]    v_reg [8];
    logic [31:0]    w_reg [16];
    logic [2:0]     out_idx_reg;
    logic           out_valid_reg;

    // message schedule and round datapath
    logic [31:0] w_cur, w_new, s0, s1, e, a, big1, ch, big0, maj, t1, t2;
    always_comb
    begin
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        e = v_reg[4];
        a = v_reg[0];
        big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
        ch   = (e & v_reg[5]) ^ (~e & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + shs_pkg::round_k(idx_reg) + w_cur;
        big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
        maj  = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_idx_reg, h_reg[out_idx_reg]};
    assign m_tlast   = (out_idx_reg == 3'd7);

    // pad byte value for a given position
    logic [7:0] pad_byte;
    always_comb
    begin
        if (second_reg == 1'b0 && idx_reg == fill_reg && !finishing_reg)
            pad_byte = 8'h80;
        else if (idx_reg >= 6'd56 && !(fill_reg >= 6'd56 && !second_reg))
            pad_byte = total_reg[8'd63 - {idx_reg[2:0], 3'b000} -: 8];
        else
            pad_byte = 8'h00;
    end

    // block buffer byte-lane writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid && !cmd.finish)
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= cmd.data;
        else if (state_reg == ST_PAD)
            buf_mem[idx_reg[5:2]][{~idx_reg[1:0], 3'b000} +: 8] <= pad_byte;
    end

    // schedule window: load shifts in one buffered word each cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= buf_mem[idx_reg[3:0]];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            total_reg     <= '0;
            finishing_reg <= 1'b0;
            second_reg    <= 1'b0;
            idx_reg       <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shs_pkg::init_h(3'(i));
                v_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.finish)
                        begin
                            total_reg     <= bits_reg + {55'd0, fill_reg, 3'd0};
                            finishing_reg <= 1'b0;
                            second_reg    <= 1'b0;
                            idx_reg       <= fill_reg;
                            state_reg     <= ST_PAD;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            if (fill_reg == 6'd63)
                            begin
                                bits_reg  <= bits_reg + 64'd512;
                                idx_reg   <= '0;
                                state_reg <= ST_LOAD;
                            end
                        end
                    end
                end
                ST_PAD:
                begin
                    // first pass marks the 0x80 byte via finishing_reg clear
                    if (idx_reg == fill_reg && !second_reg)
                        finishing_reg <= 1'b1;
                    if (idx_reg == 6'd63)
                    begin
                        finishing_reg <= 1'b1;
                        idx_reg       <= '0;
                        state_reg     <= ST_LOAD;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    if (idx_reg == 6'd15)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_ROUND;
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= e;
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= a;
                    v_reg[0] <= t1 + t2;
                    idx_reg  <= idx_reg + 1'b1;
                    if (idx_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    if (!finishing_reg)
                        state_reg <= ST_IDLE;
                    else if (fill_reg >= 6'd56 && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        idx_reg    <= '0;
                        state_reg  <= ST_PAD;
                    end
                    else
                    begin
                        out_idx_reg   <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 3'd7)
                        begin
                            out_valid_reg <= 1'b0;
                            fill_reg      <= '0;
                            bits_reg      <= '0;
                            finishing_reg <= 1'b0;
                            second_reg    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= shs_pkg::init_h(3'(i));
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/shs_checker.sv */
// ---------------------------------------------------------------------------
// sha256 stream hasher port checker
// watches output word ordering on the top level ports
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module shs_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    input  wire logic [39:0]   m_axis_tdata,
    input  wire logic          m_axis_tlast
);
    // last marks exactly the eighth word
    `SHS_ASSERT_IMP(a_last_idx, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[34:32] == 3'd7), "tlast does not match word index")
    // a taken word that is not last is followed by the next index
    `SHS_ASSERT_NEXT(a_idx_step, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1, "word index skipped")
    // after the last word the output goes quiet
    `SHS_ASSERT_NEXT(a_end_quiet, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "word after last")
    // stalled word holds
    `SHS_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256 stream hasher testbench
// feeds byte messages with finish words, predicts each digest with a local
// SHA-256 and compares every digest word, index and last flag in order
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    sha256_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    typedef struct {
        logic        func;
        logic [7:0]  data;
        logic        known;
        logic [31:0] word0;
    } stim_row_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned fill_count;
    logic [63:0] bit_count;

    digest_word_t digest_queue [$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  n_items;
    logic         busy_recv;
    logic         calm_phase;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic restart_message();
        hash_state = H_INIT;
        fill_count = 0;
        bit_count  = '0;
    endtask

    // advance the predictor by one accepted word
    task automatic predict_word(input logic func, input logic [7:0] data);
        logic [63:0]  total;
        digest_word_t d;
        if (func == shs_pkg::FUNC_ABSORB)
        begin
            msg_block[fill_count] = data;
            fill_count++;
            if (fill_count == 64)
            begin
                compress_block();
                bit_count  = bit_count + 64'd512;
                fill_count = 0;
            end
        end
        else
        begin
            total = bit_count + 64'(fill_count * 8);
            msg_block[fill_count] = 8'h80;
            for (int i = fill_count + 1; i < 64; i++)
                msg_block[i] = 8'h00;
            // long tail needs a second block
            if (fill_count >= 56)
            begin
                compress_block();
                for (int i = 0; i < 56; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[56+i] = total[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                digest_queue.push_back(d);
            end
            restart_message();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // receive side with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $display("%0t unexpected word: actual %h", $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    digest_word_t e;
                    e = digest_queue.pop_front();
                    if (m_axis_tdata[31:0] !== e.digest_word)
                    begin
                        $display("%0t digest_word[%0d]: expected %h actual %h", $time,
                                 e.word_index, e.digest_word, m_axis_tdata[31:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[34:32] !== e.word_index)
                    begin
                        $display("%0t word_index: expected %0d actual %0d", $time,
                                 e.word_index, m_axis_tdata[34:32]);
                        error_count++;
                    end
                    if (m_axis_tlast !== e.last_word)
                    begin
                        $display("%0t last_word: expected %b actual %b", $time,
                                 e.last_word, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= calm_phase || ($urandom_range(99) >= 8);
        end
    end

    // send one word, idling at random beforehand
    task automatic send_word(input logic func, input logic [7:0] data);
        while (!calm_phase && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_word(func, data);
        n_items++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_word(shs_pkg::FUNC_ABSORB, 8'($urandom));
        send_word(shs_pkg::FUNC_FINISH, 8'($urandom));
    endtask

    stim_row_t directed [$];
    int unsigned len;

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = shs_pkg::FUNC_ABSORB;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        n_items       = 0;
        calm_phase    = 1'b0;
        restart_message();
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;

        // empty message, "abc", extremes of the byte, finish with data ignored
        directed = '{
            '{shs_pkg::FUNC_FINISH, 8'hff, 1'b1, 32'he3b0c442},
            '{shs_pkg::FUNC_ABSORB, 8'h61, 1'b0, 32'h0},
            '{shs_pkg::FUNC_ABSORB, 8'h62, 1'b0, 32'h0},
            '{shs_pkg::FUNC_ABSORB, 8'h63, 1'b0, 32'h0},
            '{shs_pkg::FUNC_FINISH, 8'h00, 1'b1, 32'hba7816bf},
            '{shs_pkg::FUNC_ABSORB, 8'h00, 1'b0, 32'h0},
            '{shs_pkg::FUNC_ABSORB, 8'hff, 1'b0, 32'h0},
            '{shs_pkg::FUNC_ABSORB, 8'haa, 1'b0, 32'h0},
            '{shs_pkg::FUNC_ABSORB, 8'h55, 1'b0, 32'h0},
            '{shs_pkg::FUNC_FINISH, 8'h5a, 1'b0, 32'h0},
            '{shs_pkg::FUNC_FINISH, 8'h00, 1'b1, 32'he3b0c442}};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first word of the digest just predicted sits eight from the back
        foreach (directed[r])
        begin
            send_word(directed[r].func, directed[r].data);
            if (directed[r].known &&
                digest_queue[digest_queue.size() - 8].digest_word !== directed[r].word0)
            begin
                $display("%0t known digest: expected %h actual %h", $time,
                         directed[r].word0,
                         digest_queue[digest_queue.size() - 8].digest_word);
                error_count++;
            end
        end

        // long tail at both ends and a full buffer
        send_message(56);
        send_message(63);
        calm_phase = 1'b1;
        send_message(64);
        calm_phase = 1'b0;

        // random short messages
        while (n_items < 220)
        begin
            len = $urandom_range(12);
            send_message(len);
        end
        s_axis_tvalid <= 1'b0;

        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
